// ===== hdl/arith_expr_tokenizer_core_assert.svh =====
// ----------------------------------------------------------------------------
// arith_expr_tokenizer_core_assert.svh
// Assertion macros shared by the tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef ARITH_EXPR_TOKENIZER_CORE_ASSERT_SVH
`define ARITH_EXPR_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define AETK_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AETK_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hdl/aetk_pkg.sv =====
// ----------------------------------------------------------------------------
// aetk_pkg
// Shared types and constants of the arithmetic expression tokenizer.
// ----------------------------------------------------------------------------
package aetk_pkg;

  // Default width of the digit accumulator
  localparam int VALUE_BITS_DEF = 31;

  // Width of the number field on the result channel
  localparam int NUM_OUT_BITS = 31;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Token kinds
  typedef enum logic [3:0] {
    KIND_END    = 4'd0,
    KIND_UNDEF  = 4'd1,
    KIND_LPAREN = 4'd2,
    KIND_RPAREN = 4'd3,
    KIND_NUMBER = 4'd4,
    KIND_ADD    = 4'd5,
    KIND_SUB    = 4'd6,
    KIND_MUL    = 4'd7,
    KIND_DIV    = 4'd8
  } tok_kind_t;

  // One queue entry: everything one input item produces
  typedef struct packed {
    logic                    has_num;
    logic [NUM_OUT_BITS-1:0] num_val;
    logic                    num_ovf;
    logic                    has_tok;
    tok_kind_t               tok_kind;
  } qentry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

// ===== hdl/aetk_front.sv =====
// ----------------------------------------------------------------------------
// aetk_front
// Accepts text bytes, builds digit runs and classifies each byte into a
// queue entry holding a pending number and/or a token.
// ----------------------------------------------------------------------------
module aetk_front import aetk_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_text,
  input  qstat_t     q_stat,
  output logic       q_push,
  output qentry_t    q_wdata
);

  localparam int WIDE_BITS = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  logic                  in_number_r, in_number_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  ovf_r, ovf_nxt;

  logic                  accept;
  logic                  is_digit;
  logic                  is_space;
  logic [WIDE_BITS-1:0]  acc_ext;
  logic [WIDE_BITS-1:0]  wide;
  logic                  sat;
  tok_kind_t             kind;
  logic [NUM_OUT_BITS-1:0] acc_out;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Byte classification
  assign is_digit = (in_char_byte >= CH_ZERO) && (in_char_byte <= CH_NINE);

  always_comb begin
    is_space = 1'b0;
    kind     = KIND_UNDEF;
    unique case (in_char_byte) inside
      CH_SPACE, CH_TAB, CH_LF, CH_CR: is_space = 1'b1;
      CH_LPAREN: kind = KIND_LPAREN;
      CH_RPAREN: kind = KIND_RPAREN;
      CH_PLUS:   kind = KIND_ADD;
      CH_MINUS:  kind = KIND_SUB;
      CH_STAR:   kind = KIND_MUL;
      CH_SLASH:  kind = KIND_DIV;
      default:   kind = KIND_UNDEF;
    endcase
  end

  // acc*10 + digit as shift-add, overflow from the top bits
  assign acc_ext = {4'b0, acc_r};
  assign wide    = (acc_ext << 3) + (acc_ext << 1)
                 + {{(WIDE_BITS-4){1'b0}}, in_char_byte[3:0]};
  assign sat     = ovf_r || (|wide[WIDE_BITS-1:VALUE_BITS]);

  // Accumulator to result field width
  generate
    if (VALUE_BITS >= NUM_OUT_BITS) begin : g_trunc
      assign acc_out = acc_r[NUM_OUT_BITS-1:0];
    end else begin : g_ext
      assign acc_out = {{(NUM_OUT_BITS-VALUE_BITS){1'b0}}, acc_r};
    end
  endgenerate

  // Number state update
  always_comb begin
    in_number_nxt = in_number_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    if (accept) begin
      if (!in_end_of_text && is_digit) begin
        in_number_nxt = 1'b1;
        acc_nxt       = sat ? VALUE_MAX : wide[VALUE_BITS-1:0];
        ovf_nxt       = sat;
      end else begin
        in_number_nxt = 1'b0;
        acc_nxt       = '0;
        ovf_nxt       = 1'b0;
      end
    end
  end

  // Queue entry
  always_comb begin
    q_wdata.has_num  = in_number_r && (in_end_of_text || !is_digit);
    q_wdata.num_val  = acc_out;
    q_wdata.num_ovf  = ovf_r;
    q_wdata.has_tok  = in_end_of_text || (!is_digit && !is_space);
    q_wdata.tok_kind = in_end_of_text ? KIND_END : kind;
  end

  assign q_push = accept && (q_wdata.has_num || q_wdata.has_tok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_number_r <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      in_number_r <= in_number_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

endmodule

// ===== hdl/aetk_queue.sv =====
// ----------------------------------------------------------------------------
// aetk_queue
// Small register queue of per-item entries between front and back.
// ----------------------------------------------------------------------------
module aetk_queue import aetk_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t wdata,
  input  logic    pop,
  output qentry_t rdata,
  output qstat_t  stat
);

  qentry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== hdl/aetk_back.sv =====
// ----------------------------------------------------------------------------
// aetk_back
// Expands queue entries into one or two tokens and holds them in the
// output register until taken.
// ----------------------------------------------------------------------------
module aetk_back import aetk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qentry_t                 q_rdata,
  input  qstat_t                  q_stat,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_token_kind,
  output logic [NUM_OUT_BITS-1:0] out_number_value,
  output logic                    out_overflow,
  output logic                    out_last_of_run
);

  logic                    valid_r, valid_nxt;
  logic                    phase_r, phase_nxt;   // number part of head already sent
  tok_kind_t               kind_r, kind_nxt;
  logic [NUM_OUT_BITS-1:0] val_r, val_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    last_r, last_nxt;
  logic                    load_ok;

  assign load_ok = !valid_r || !out_stall;

  // Token selection from the head entry
  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    val_nxt   = val_r;
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load_ok) begin
      valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        if (q_rdata.has_num && !phase_r) begin
          kind_nxt  = KIND_NUMBER;
          val_nxt   = q_rdata.num_val;
          ovf_nxt   = q_rdata.num_ovf;
          last_nxt  = !q_rdata.has_tok;
          phase_nxt = q_rdata.has_tok;
          q_pop     = !q_rdata.has_tok;
        end else begin
          kind_nxt  = q_rdata.tok_kind;
          val_nxt   = '0;
          ovf_nxt   = 1'b0;
          last_nxt  = 1'b1;
          phase_nxt = 1'b0;
          q_pop     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    val_r  <= val_nxt;
    ovf_r  <= ovf_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_token_kind   = kind_r;
  assign out_number_value = val_r;
  assign out_overflow     = ovf_r;
  assign out_last_of_run  = last_r;

endmodule

// ===== hdl/arith_expr_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// arith_expr_tokenizer_core
// Streaming lexer for arithmetic expression text: bytes in, tokens out.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid/in_stall, char_byte, end_of_text| in
//  result  | out_valid/out_stall, token_kind,        | out
//          | number_value, overflow, last_of_run     |
//
//  The front takes one item per cycle unless in_stall holds it; digit
//  accumulation is one shift-add. An item that yields a number and a token
//  gives two results from the output register, the number first.
//  A four-entry queue between front and back sets how long the input
//  keeps flowing while the result side is stalled; in_stall rises when full.
//  Reset is synchronous, active low: it empties the queue and clears the
//  number state at once; no clearing pass.
// ----------------------------------------------------------------------------
module arith_expr_tokenizer_core import aetk_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_char_byte,
  input  logic                    in_end_of_text,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_token_kind,
  output logic [NUM_OUT_BITS-1:0] out_number_value,
  output logic                    out_overflow,
  output logic                    out_last_of_run
);

  qstat_t  q_stat;
  qentry_t q_wdata, q_rdata;
  logic    q_push, q_pop;

  // Front: accept and classify
  aetk_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_byte   (in_char_byte),
    .in_end_of_text (in_end_of_text),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // Decoupling queue
  aetk_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: token emission
  aetk_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rdata          (q_rdata),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_overflow     (out_overflow),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ===== hdl/aetk_checker.sv =====
// ----------------------------------------------------------------------------
// aetk_checker
// Port-level checks on the tokenizer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "arith_expr_tokenizer_core_assert.svh"

module aetk_checker import aetk_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [3:0]              out_token_kind,
  input logic [NUM_OUT_BITS-1:0] out_number_value,
  input logic                    out_overflow,
  input logic                    out_last_of_run
);

  // A stalled result holds
  `AETK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({out_token_kind, out_number_value, out_overflow, out_last_of_run}), "stalled item changed")

  // Only number tokens carry a value or overflow
  `AETK_ASSERT_NOW(a_non_number_zero, clk, rst_n, out_valid && (out_token_kind != KIND_NUMBER), (out_number_value == '0) && !out_overflow, "non-number token carries value")

  // Token kind within range
  `AETK_ASSERT_NOW(a_kind_range, clk, rst_n, out_valid, out_token_kind <= KIND_DIV, "token kind out of range")

  // End token always closes its run
  `AETK_ASSERT_NOW(a_end_last, clk, rst_n, out_valid && (out_token_kind == KIND_END), out_last_of_run, "end token not last of run")

endmodule

bind arith_expr_tokenizer_core aetk_checker u_aetk_checker (.*);

// ===== bench/tb_arith_expr_tokenizer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arith_expr_tokenizer_core
// Self-checking bench for the expression tokenizer. A short run of hand-built
// text hits every token kind, each whitespace byte, unlisted bytes and
// back-to-back end markers. Random expressions with numbers near and past the
// saturation point follow, mixed with noise and damaged text, under four
// sender/receiver idle mixes. Every token is checked against a lexer model
// kept inside the bench.
// ----------------------------------------------------------------------------

import aetk_pkg::*;

// Largest value a digit run can hold before it saturates
localparam longint unsigned DIGIT_VALUE_MAX = (64'd1 << VALUE_BITS_DEF) - 64'd1;

// One token as it leaves the block
typedef struct {
  tok_kind_t               kind;
  logic [NUM_OUT_BITS-1:0] value;
  logic                    ovf;
  logic                    last;
} token_t;

// Lexer model plus the queue of tokens still owed by the block
class token_scoreboard;
  bit              in_number;
  longint unsigned acc;
  bit              ovf_seen;
  token_t          owed_tokens[$];
  int unsigned     compared;
  int unsigned     saturated;
  int unsigned     mismatches;

  // Accepted input item: advance the lexer and queue what it emits
  function void note_byte(logic [7:0] ch, logic eot);
    token_t          num_tok;
    token_t          op_tok;
    bit              has_num;
    bit              has_op;
    longint unsigned digit;
    has_num = 1'b0;
    has_op  = 1'b0;
    num_tok = '{KIND_NUMBER, acc[NUM_OUT_BITS-1:0], ovf_seen, 1'b0};
    op_tok  = '{KIND_END, '0, 1'b0, 1'b0};
    if (!eot && ch >= CH_ZERO && ch <= CH_NINE) begin
      digit = ch - CH_ZERO;
      if (!in_number) begin
        in_number = 1'b1;
        acc       = 0;
        ovf_seen  = 1'b0;
      end
      // saturate once the next multiply-add would pass the max
      if (ovf_seen || acc > (DIGIT_VALUE_MAX - digit) / 10) begin
        ovf_seen = 1'b1;
        acc      = DIGIT_VALUE_MAX;
      end else begin
        acc = acc * 10 + digit;
      end
    end else begin
      // any non-digit or end marker flushes a pending number first
      has_num   = in_number;
      in_number = 1'b0;
      acc       = 0;
      ovf_seen  = 1'b0;
      has_op    = 1'b1;
      if (!eot) begin
        case (ch)
          CH_SPACE, CH_TAB, CH_LF, CH_CR: has_op = 1'b0;
          CH_LPAREN: op_tok.kind = KIND_LPAREN;
          CH_RPAREN: op_tok.kind = KIND_RPAREN;
          CH_PLUS:   op_tok.kind = KIND_ADD;
          CH_MINUS:  op_tok.kind = KIND_SUB;
          CH_STAR:   op_tok.kind = KIND_MUL;
          CH_SLASH:  op_tok.kind = KIND_DIV;
          default:   op_tok.kind = KIND_UNDEF;
        endcase
      end
    end
    if (has_num) begin
      num_tok.last = !has_op;
      owed_tokens.push_back(num_tok);
    end
    if (has_op) begin
      op_tok.last = 1'b1;
      owed_tokens.push_back(op_tok);
    end
  endfunction

  // Accepted result: compare with the oldest owed token
  function void check_token(logic [3:0] kind, logic [NUM_OUT_BITS-1:0] value,
                            logic ovf, logic last);
    token_t want;
    if (owed_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected token kind=%0d value=%0d ovf=%0b last=%0b",
                 kind, value, ovf, last);
      return;
    end
    want = owed_tokens.pop_front();
    compared++;
    if (kind !== want.kind || value !== want.value || ovf !== want.ovf ||
        last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: token %0d exp kind=%s value=%0d ovf=%0b last=%0b, got kind=%0d value=%0d ovf=%0b last=%0b",
                 compared, want.kind.name(), want.value, want.ovf, want.last,
                 kind, value, ovf, last);
    end else if (want.ovf) begin
      saturated++;
    end
  endfunction
endclass

module tb_arith_expr_tokenizer_core;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  localparam logic [7:0] OP_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  localparam logic [7:0] WS_CHARS [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              in_char_byte = 8'h00;
  logic                    in_end_of_text = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [3:0]              out_token_kind;
  logic [NUM_OUT_BITS-1:0] out_number_value;
  logic                    out_overflow;
  logic                    out_last_of_run;

  int unsigned     sender_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     bytes_sent = 0;
  text_item_t      text_q[$];
  token_scoreboard board = new;

  always #5 clk = ~clk;

  arith_expr_tokenizer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_overflow     (out_overflow),
    .out_last_of_run  (out_last_of_run)
  );

  // Result side: check on accept, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_token(out_token_kind, out_number_value, out_overflow, out_last_of_run);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Text building
  function automatic void push_ch(logic [7:0] ch);
    text_q.push_back('{ch, 1'b0});
  endfunction

  function automatic void push_gap();
    if ($urandom_range(3) == 0)
      push_ch(WS_CHARS[$urandom_range(3)]);
  endfunction

  function automatic void push_number(longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++)
      push_ch(s[i]);
  endfunction

  // Mostly short values, some right at the saturation edge, some far past it
  function automatic longint unsigned pick_number();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(9);
      4, 5:       return $urandom_range(99999);
      6:          return 64'd2147483637 + $urandom_range(20);
      7:          return {$urandom, $urandom};
      8:          return $urandom;
      default:    return $urandom_range(999);
    endcase
  endfunction

  // Well-formed expression with random content, closed by an end marker
  function automatic void fill_expression();
    int terms;
    int depth;
    terms = $urandom_range(1, 6);
    depth = 0;
    for (int t = 0; t < terms; t++) begin
      push_gap();
      while (depth < 4 && $urandom_range(3) == 0) begin
        push_ch(CH_LPAREN);
        depth++;
        push_gap();
      end
      if ($urandom_range(9) == 0)
        push_ch(CH_ZERO);
      push_number(pick_number());
      push_gap();
      while (depth > 0 && $urandom_range(2) == 0) begin
        push_ch(CH_RPAREN);
        depth--;
      end
      if (t < terms - 1) begin
        push_gap();
        push_ch(OP_CHARS[$urandom_range(3)]);
      end
    end
    while (depth > 0) begin
      push_ch(CH_RPAREN);
      depth--;
    end
    push_gap();
    text_q.push_back('{8'($urandom_range(255)), 1'b1});
  endfunction

  // Drain the text queue into the block, one item per handshake
  task automatic send_text();
    text_item_t it;
    while (text_q.size() != 0) begin
      it = text_q.pop_front();
      while ($urandom_range(99) < sender_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid       <= 1'b1;
      in_char_byte   <= it.ch;
      in_end_of_text <= it.eot;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      board.note_byte(it.ch, it.eot);
      bytes_sent++;
    end
  endtask

  // Main sequence
  initial begin
    string       edge_text;
    int unsigned seg;
    int unsigned roll;
    int unsigned idx;
    int unsigned base;
    edge_text = "(12+3)*4-5/6 \t\n\015%";
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every kind, whitespace, unlisted bytes, number then end, end twice
    for (int i = 0; i < edge_text.len(); i++)
      push_ch(edge_text[i]);
    push_ch(8'h00);
    push_ch(8'hFF);
    push_ch(CH_NINE);
    text_q.push_back('{8'hA5, 1'b1});
    text_q.push_back('{8'h00, 1'b1});
    send_text();
    base = bytes_sent;

    // random: eight segments cycling through the idle mixes
    for (seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      while (bytes_sent < base + (seg + 1) * 235) begin
        roll = $urandom_range(99);
        if (roll < 80) begin
          fill_expression();
        end else if (roll < 90) begin
          // damaged expression: one byte replaced, sometimes no end marker
          fill_expression();
          idx = $urandom_range(text_q.size() - 1);
          text_q[idx] = '{8'($urandom_range(255)), 1'($urandom_range(3) == 0)};
          if ($urandom_range(1) == 0)
            void'(text_q.pop_back());
        end else begin
          repeat ($urandom_range(1, 8))
            text_q.push_back('{8'($urandom_range(255)), 1'($urandom_range(15) == 0)});
        end
        send_text();
      end
    end
    in_valid <= 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;

    // wait for the last owed token, then a quiet spell for strays
    while (board.owed_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d text bytes: edge text, random expressions, noise and damaged text",
             bytes_sent);
    $display("under four idle mixes; %0d tokens compared, %0d saturated numbers, %0d mismatches.",
             board.compared, board.saturated, board.mismatches);
    if (board.mismatches == 0 && board.owed_tokens.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Timeout with %0d tokens still owed", board.owed_tokens.size());
    $display("FAILURE");
    $finish;
  end

endmodule
